// ===== src/pid_height_force_controller_top_defines.svh =====
// Assertion macros for the height force controller.
`ifndef PID_HEIGHT_FORCE_CONTROLLER_TOP_DEFINES_SVH
`define PID_HEIGHT_FORCE_CONTROLLER_TOP_DEFINES_SVH

`ifndef SYNTHESIS
`define PHFC_ASSERT_CLK(lbl, clk, rst, prop, msg) \
   lbl: assert property (@(posedge clk) disable iff (rst) (prop)) else $error(msg);
`define PHFC_ASSERT(lbl, prop, msg) `PHFC_ASSERT_CLK(lbl, clock, reset, prop, msg)
`else
`define PHFC_ASSERT_CLK(lbl, clk, rst, prop, msg)
`define PHFC_ASSERT(lbl, prop, msg)
`endif

`endif

// ===== src/phfc_pkg.sv =====
// Shared types and constants of the height force controller.
`default_nettype none

package phfc_pkg;

   localparam int DATA_W     = 32;
   localparam int DT_W       = 31;
   localparam int DIFF_W     = 33;
   localparam int PROD_W     = 64;
   localparam int CSR_ADDR_W = 5;
   localparam int CSR_DATA_W = 32;
   localparam int DTERM_EXP  = 56;

   localparam logic [PROD_W-1:0] DTERM_LIM = PROD_W'(1) << DTERM_EXP;
   localparam logic signed [DATA_W-1:0] WORD_MAX = {1'b0, {(DATA_W-1){1'b1}}};
   localparam logic signed [DATA_W-1:0] WORD_MIN = {1'b1, {(DATA_W-1){1'b0}}};

   typedef enum logic [2:0] {
      REG_MODE   = 3'd0,
      REG_START  = 3'd1,
      REG_SPRING = 3'd2,
      REG_KP     = 3'd3,
      REG_KI     = 3'd4,
      REG_KD     = 3'd5,
      REG_SCALE  = 3'd6
   } phfc_reg_type;

   typedef enum logic [3:0] {
      ST_IDLE,
      ST_ERR,
      ST_D_MUL,
      ST_D_WAIT,
      ST_DIV,
      ST_DIV_WAIT,
      ST_P_MUL,
      ST_P_WAIT,
      ST_I_MUL,
      ST_I_WAIT,
      ST_SUM,
      ST_O_MUL,
      ST_S_MUL,
      ST_F_WAIT,
      ST_RESULT
   } phfc_state_type;

   typedef struct packed {
      logic busy;
      logic done;
   } phfc_unit_stat_type;

   typedef struct packed {
      logic                     clip;
      logic signed [DATA_W-1:0] value;
   } phfc_sat_type;

endpackage

`default_nettype wire

// ===== src/phfc_if.sv =====
// Item channel interfaces: measured height in, force out.
`default_nettype none

interface phfc_req_if import phfc_pkg::*; ();
   logic                     valid;
   logic                     ready;
   logic signed [DATA_W-1:0] height;
   logic [DT_W-1:0]          time_step;

   modport source (output valid, height, time_step, input ready);
   modport sink (input valid, height, time_step, output ready);
endinterface

interface phfc_rsp_if import phfc_pkg::*; ();
   logic                     valid;
   logic                     ready;
   logic signed [DATA_W-1:0] force_res;
   logic                     saturated;
   logic                     zero_time_step;

   modport source (output valid, force_res, saturated, zero_time_step, input ready);
   modport sink (input valid, force_res, saturated, zero_time_step, output ready);
endinterface

`default_nettype wire

// ===== src/phfc_mul.sv =====
// Bit-serial signed multiplier, one multiplier bit per cycle.
`default_nettype none

module phfc_mul import phfc_pkg::*; (
   input  wire logic                     clock,
   input  wire logic                     reset,
   input  wire logic                     start,
   input  wire logic signed [DIFF_W-1:0] a,
   input  wire logic signed [DATA_W-1:0] b,
   output logic signed [PROD_W-1:0]      product,
   output phfc_unit_stat_type            stat
);

   localparam int CNT_W = $clog2(DATA_W + 1);

   logic [PROD_W-1:0] mcand_ff;
   logic [DATA_W-1:0] mplier_ff;
   logic [PROD_W-1:0] acc_ff;
   logic              neg_ff;
   logic [CNT_W-1:0]  cnt_ff;
   logic              busy_ff;
   logic              done_ff;
   logic [DIFF_W-1:0] a_mag;
   logic [DATA_W-1:0] b_mag;

   // two's complement negation read as unsigned gives the magnitude
   assign a_mag = a[DIFF_W-1] ? DIFF_W'(-a) : DIFF_W'(a);
   assign b_mag = b[DATA_W-1] ? DATA_W'(-b) : DATA_W'(b);

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
      end else begin
         done_ff <= 1'b0;
         if (start) begin
            busy_ff   <= 1'b1;
            mcand_ff  <= PROD_W'(a_mag);
            mplier_ff <= b_mag;
            acc_ff    <= '0;
            neg_ff    <= a[DIFF_W-1] ^ b[DATA_W-1];
            cnt_ff    <= CNT_W'(DATA_W);
         end else if (busy_ff) begin
            if (mplier_ff[0]) begin
               acc_ff <= acc_ff + mcand_ff;
            end
            mcand_ff  <= {mcand_ff[PROD_W-2:0], 1'b0};
            mplier_ff <= {1'b0, mplier_ff[DATA_W-1:1]};
            cnt_ff    <= cnt_ff - CNT_W'(1);
            if (cnt_ff == CNT_W'(1)) begin
               busy_ff <= 1'b0;
               done_ff <= 1'b1;
            end
         end
      end
   end

   assign product = neg_ff ? -$signed(acc_ff) : $signed(acc_ff);

   always_comb begin
      stat.busy = busy_ff;
      stat.done = done_ff;
   end

endmodule

`default_nettype wire

// ===== src/phfc_div.sv =====
// Restoring divider, one quotient bit per cycle, truncating toward zero.
`default_nettype none

module phfc_div import phfc_pkg::*; (
   input  wire logic                     clock,
   input  wire logic                     reset,
   input  wire logic                     start,
   input  wire logic signed [PROD_W-1:0] dividend,
   input  wire logic [DT_W-1:0]          divisor,
   output logic [PROD_W-1:0]             quot_mag,
   output logic                          quot_neg,
   output phfc_unit_stat_type            stat
);

   localparam int CNT_W = $clog2(PROD_W + 1);

   logic [PROD_W-1:0] num_ff;
   logic [DT_W-1:0]   rem_ff;
   logic [DT_W-1:0]   dvs_ff;
   logic              neg_ff;
   logic [CNT_W-1:0]  cnt_ff;
   logic              busy_ff;
   logic              done_ff;
   logic [DT_W:0]     trial;
   logic [DT_W:0]     trial_sub;
   logic              fits;
   logic [PROD_W-1:0] num_mag;

   assign num_mag   = dividend[PROD_W-1] ? PROD_W'(-dividend) : PROD_W'(dividend);
   assign trial     = {rem_ff, num_ff[PROD_W-1]};
   assign trial_sub = trial - {1'b0, dvs_ff};
   assign fits      = trial >= {1'b0, dvs_ff};

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
      end else begin
         done_ff <= 1'b0;
         if (start) begin
            busy_ff <= 1'b1;
            num_ff  <= num_mag;
            rem_ff  <= '0;
            dvs_ff  <= divisor;
            neg_ff  <= dividend[PROD_W-1];
            cnt_ff  <= CNT_W'(PROD_W);
         end else if (busy_ff) begin
            rem_ff <= fits ? trial_sub[DT_W-1:0] : trial[DT_W-1:0];
            num_ff <= {num_ff[PROD_W-2:0], fits};
            cnt_ff <= cnt_ff - CNT_W'(1);
            if (cnt_ff == CNT_W'(1)) begin
               busy_ff <= 1'b0;
               done_ff <= 1'b1;
            end
         end
      end
   end

   assign quot_mag = num_ff;
   assign quot_neg = neg_ff;

   always_comb begin
      stat.busy = busy_ff;
      stat.done = done_ff;
   end

endmodule

`default_nettype wire

// ===== src/pid_height_force_controller_top.sv =====
// Top level of the height force controller: registers, sequencer, serial arithmetic.
// PID mode: the result is registered after four passes of the bit-serial multiplier plus
// the divider pass; with a zero time step the divider pass is skipped.
// Spring mode: one multiplier pass. One item at a time: the next item is taken only
// after the result enters the output register, which waits while the output is held.
// Synchronous active-high reset loads register defaults, clears error history and valid.
`default_nettype none
`include "pid_height_force_controller_top_defines.svh"

module pid_height_force_controller_top import phfc_pkg::*; #(
   parameter int FRAC_BITS = 16
) (
   input  wire logic                  clock,
   input  wire logic                  reset,
   phfc_req_if.sink                   req_if,
   phfc_rsp_if.source                 rsp_if,
   input  wire logic                  psel,
   input  wire logic                  penable,
   input  wire logic                  pwrite,
   input  wire logic [CSR_ADDR_W-1:0] paddr,
   input  wire logic [CSR_DATA_W-1:0] pwdata,
   output logic [CSR_DATA_W-1:0]      prdata,
   output logic                       pready
);

   localparam logic signed [DATA_W-1:0] UNITY = DATA_W'(1 << FRAC_BITS);

   function automatic phfc_sat_type saturate(input logic signed [PROD_W-1:0] v);
      phfc_sat_type r;
      logic         hi_ones;
      logic         hi_zeros;
      hi_ones  = &v[PROD_W-1:DATA_W-1];
      hi_zeros = ~|v[PROD_W-1:DATA_W-1];
      r.clip   = !(hi_ones || hi_zeros);
      if (r.clip) begin
         r.value = v[PROD_W-1] ? WORD_MIN : WORD_MAX;
      end else begin
         r.value = v[DATA_W-1:0];
      end
      return r;
   endfunction

   // configuration
   logic                     mode_ff;
   logic signed [DATA_W-1:0] start_h_ff;
   logic signed [DATA_W-1:0] spring_ff;
   logic signed [DATA_W-1:0] kp_ff;
   logic signed [DATA_W-1:0] ki_ff;
   logic signed [DATA_W-1:0] kd_ff;
   logic signed [DATA_W-1:0] scale_ff;
   logic                     csr_wr;
   phfc_reg_type             csr_reg;

   // sequencer and datapath
   phfc_state_type           state_ff;
   phfc_state_type           state_in;
   logic signed [DIFF_W-1:0] diff_ff;
   logic [DT_W-1:0]          dt_ff;
   logic signed [DATA_W-1:0] prev_err_ff;
   logic signed [DATA_W-1:0] err_sum_ff;
   logic signed [DATA_W-1:0] e_ff;
   logic signed [DIFF_W-1:0] de_ff;
   logic signed [DATA_W-1:0] inner_ff;
   logic signed [DATA_W-1:0] force_ff;
   logic signed [PROD_W-1:0] acc_ff;
   logic                     sat_ff;
   logic                     zdt_ff;
   logic                     rsp_valid_ff;
   logic signed [DATA_W-1:0] rsp_force_ff;
   logic                     rsp_sat_ff;
   logic                     rsp_zdt_ff;

   logic signed [DIFF_W-1:0] diff_in;
   phfc_sat_type             e_res;
   phfc_sat_type             sum_res;
   phfc_sat_type             inner_res;
   phfc_sat_type             force_c;
   logic signed [DIFF_W-1:0] de_in;
   logic signed [PROD_W-1:0] prod_shift;
   logic                     q_clip;
   logic [PROD_W-1:0]        d_mag;
   logic signed [PROD_W-1:0] dterm;

   // arithmetic units
   logic                     mul_start;
   logic signed [DIFF_W-1:0] mul_a;
   logic signed [DATA_W-1:0] mul_b;
   logic signed [PROD_W-1:0] mul_product;
   phfc_unit_stat_type       mul_stat;
   logic                     div_start;
   logic [PROD_W-1:0]        div_quot;
   logic                     div_neg;
   phfc_unit_stat_type       div_stat;

   phfc_mul u_mul (
      .clock   (clock),
      .reset   (reset),
      .start   (mul_start),
      .a       (mul_a),
      .b       (mul_b),
      .product (mul_product),
      .stat    (mul_stat)
   );

   phfc_div u_div (
      .clock    (clock),
      .reset    (reset),
      .start    (div_start),
      .dividend (mul_product),
      .divisor  (dt_ff),
      .quot_mag (div_quot),
      .quot_neg (div_neg),
      .stat     (div_stat)
   );

   // APB register port
   assign pready  = 1'b1;
   assign csr_wr  = psel && penable && pwrite;
   assign csr_reg = phfc_reg_type'(paddr[CSR_ADDR_W-1:2]);

   always_ff @(posedge clock) begin
      if (reset) begin
         mode_ff    <= 1'b0;
         start_h_ff <= '0;
         spring_ff  <= UNITY;
         kp_ff      <= '0;
         ki_ff      <= '0;
         kd_ff      <= '0;
         scale_ff   <= UNITY;
      end else if (csr_wr) begin
         case (csr_reg)
            REG_MODE:   mode_ff    <= pwdata[0];
            REG_START:  start_h_ff <= pwdata[DATA_W-1:0];
            REG_SPRING: spring_ff  <= pwdata[DATA_W-1:0];
            REG_KP:     kp_ff      <= pwdata[DATA_W-1:0];
            REG_KI:     ki_ff      <= pwdata[DATA_W-1:0];
            REG_KD:     kd_ff      <= pwdata[DATA_W-1:0];
            REG_SCALE:  scale_ff   <= pwdata[DATA_W-1:0];
            default: ;
         endcase
      end
   end

   always_comb begin
      case (csr_reg)
         REG_MODE:   prdata = {{(CSR_DATA_W-1){1'b0}}, mode_ff};
         REG_START:  prdata = start_h_ff;
         REG_SPRING: prdata = spring_ff;
         REG_KP:     prdata = kp_ff;
         REG_KI:     prdata = ki_ff;
         REG_KD:     prdata = kd_ff;
         REG_SCALE:  prdata = scale_ff;
         default:    prdata = '0;
      endcase
   end

   // datapath combinational terms
   assign diff_in    = DIFF_W'(req_if.height) - DIFF_W'(start_h_ff);
   assign e_res      = saturate(PROD_W'(diff_ff));
   assign de_in      = DIFF_W'($signed(e_res.value)) - DIFF_W'(prev_err_ff);
   assign sum_res    = saturate(PROD_W'(err_sum_ff) + PROD_W'($signed(e_res.value)));
   assign prod_shift = mul_product >>> FRAC_BITS;
   assign force_c    = saturate(prod_shift);
   assign inner_res  = saturate(acc_ff);
   assign q_clip     = div_quot > DTERM_LIM;
   assign d_mag      = q_clip ? DTERM_LIM : div_quot;
   assign dterm      = div_neg ? -$signed(d_mag) : $signed(d_mag);

   // sequencer
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

   always_comb begin
      state_in  = state_ff;
      mul_start = 1'b0;
      div_start = 1'b0;
      mul_a     = '0;
      mul_b     = '0;
      case (state_ff)
         ST_IDLE: begin
            if (req_if.valid) begin
               state_in = mode_ff ? ST_ERR : ST_S_MUL;
            end
         end
         ST_ERR: state_in = ST_D_MUL;
         ST_D_MUL: begin
            mul_start = 1'b1;
            mul_a     = de_ff;
            mul_b     = kd_ff;
            state_in  = ST_D_WAIT;
         end
         ST_D_WAIT: begin
            if (mul_stat.done) begin
               state_in = (dt_ff == '0) ? ST_P_MUL : ST_DIV;
            end
         end
         ST_DIV: begin
            div_start = 1'b1;
            state_in  = ST_DIV_WAIT;
         end
         ST_DIV_WAIT: begin
            if (div_stat.done) begin
               state_in = ST_P_MUL;
            end
         end
         ST_P_MUL: begin
            mul_start = 1'b1;
            mul_a     = DIFF_W'(e_ff);
            mul_b     = kp_ff;
            state_in  = ST_P_WAIT;
         end
         ST_P_WAIT: begin
            if (mul_stat.done) begin
               state_in = ST_I_MUL;
            end
         end
         ST_I_MUL: begin
            mul_start = 1'b1;
            mul_a     = DIFF_W'(err_sum_ff);
            mul_b     = ki_ff;
            state_in  = ST_I_WAIT;
         end
         ST_I_WAIT: begin
            if (mul_stat.done) begin
               state_in = ST_SUM;
            end
         end
         ST_SUM: state_in = ST_O_MUL;
         ST_O_MUL: begin
            mul_start = 1'b1;
            mul_a     = DIFF_W'(inner_ff);
            mul_b     = scale_ff;
            state_in  = ST_F_WAIT;
         end
         ST_S_MUL: begin
            // spring force is -(diff * gain); the negated difference still fits 33 bits
            mul_start = 1'b1;
            mul_a     = -diff_ff;
            mul_b     = spring_ff;
            state_in  = ST_F_WAIT;
         end
         ST_F_WAIT: begin
            if (mul_stat.done) begin
               state_in = ST_RESULT;
            end
         end
         ST_RESULT: begin
            if (!rsp_valid_ff || rsp_if.ready) begin
               state_in = ST_IDLE;
            end
         end
         default: state_in = ST_IDLE;
      endcase
   end

   assign req_if.ready = (state_ff == ST_IDLE);

   // datapath registers
   always_ff @(posedge clock) begin
      if (reset) begin
         prev_err_ff  <= '0;
         err_sum_ff   <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         if (state_ff == ST_RESULT && (!rsp_valid_ff || rsp_if.ready)) begin
            rsp_valid_ff <= 1'b1;
         end else if (rsp_if.ready) begin
            rsp_valid_ff <= 1'b0;
         end
         case (state_ff)
            ST_IDLE: begin
               if (req_if.valid) begin
                  diff_ff <= diff_in;
                  dt_ff   <= req_if.time_step;
                  sat_ff  <= 1'b0;
                  zdt_ff  <= 1'b0;
                  acc_ff  <= '0;
               end
            end
            ST_ERR: begin
               e_ff        <= e_res.value;
               de_ff       <= de_in;
               prev_err_ff <= e_res.value;
               err_sum_ff  <= sum_res.value;
               sat_ff      <= sat_ff | e_res.clip | sum_res.clip;
            end
            ST_D_WAIT: begin
               if (mul_stat.done && dt_ff == '0) begin
                  zdt_ff <= 1'b1;
               end
            end
            ST_DIV_WAIT: begin
               if (div_stat.done) begin
                  acc_ff <= dterm;
                  sat_ff <= sat_ff | q_clip;
               end
            end
            ST_P_WAIT, ST_I_WAIT: begin
               if (mul_stat.done) begin
                  acc_ff <= acc_ff + prod_shift;
               end
            end
            ST_SUM: begin
               inner_ff <= inner_res.value;
               sat_ff   <= sat_ff | inner_res.clip;
            end
            ST_F_WAIT: begin
               if (mul_stat.done) begin
                  force_ff <= force_c.value;
                  sat_ff   <= sat_ff | force_c.clip;
               end
            end
            ST_RESULT: begin
               if (!rsp_valid_ff || rsp_if.ready) begin
                  rsp_force_ff <= force_ff;
                  rsp_sat_ff   <= sat_ff;
                  rsp_zdt_ff   <= zdt_ff;
               end
            end
            default: ;
         endcase
      end
   end

   assign rsp_if.valid          = rsp_valid_ff;
   assign rsp_if.force_res      = rsp_force_ff;
   assign rsp_if.saturated      = rsp_sat_ff;
   assign rsp_if.zero_time_step = rsp_zdt_ff;

   `PHFC_ASSERT(a_one_item_at_a_time, (req_if.valid && req_if.ready) |=> !req_if.ready, "item accepted while busy")
   `PHFC_ASSERT(a_mul_start_idle, mul_start |-> !mul_stat.busy, "multiplier restarted while busy")
   `PHFC_ASSERT(a_div_nonzero, div_start |-> (dt_ff != '0), "divide started with zero time step")
   `PHFC_ASSERT(a_state_hold, (state_ff != ST_ERR) |=> ($stable(err_sum_ff) && $stable(prev_err_ff)), "error history changed outside update")

endmodule

`default_nettype wire
